// ----- rtl/frx_pkg.sv -----
// Shared types and constants for the sync/length frame receiver.
package frx_pkg;

  localparam logic [7:0] SYNC_FILL = 8'hAA;
  localparam logic [7:0] SYNC_LAST = 8'hAB;

  localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  typedef enum logic [1:0] {
    REQ_BYTE    = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_READ    = 2'd2
  } req_t;

  // One result word as it moves through the output pipeline.
  typedef struct packed {
    logic       frame_ready;
    logic       frame_done;
    logic       length_error;
    logic       synced;
    logic       use_ram;
    logic [7:0] read_data;
  } res_t;

endpackage

// ----- rtl/frx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/sync_length_frame_receiver.sv -----
// Top level of the sync/length frame receiver: control, header/check registers, output pipe.
//
// Takes one word per clock: a line byte, a release, or a read of a stored frame byte. A sync
// word of SYNC_LEN-1 bytes 0xAA and a closing 0xAB (extra 0xAA tolerated) starts a frame of
// HEADER_LEN header bytes (last one is the payload length), the payload and CHECK_LEN check
// bytes. Payload bytes live in one RAM with a write port and a registered read port; each line
// byte writes at most one entry and each read request reads at most one, so one word enters per
// cycle unless the input stalls; its result passes the RAM read stage, then the output register.
// A result waiting on a stalled output does not block the next word; input stalls only when
// both the RAM read stage and the output register are full. No clearing pass follows reset:
// stored bytes are defined once written. max_payload (address 0) caps the length byte; values
// above PAYLOAD_MAX act as PAYLOAD_MAX.
module sync_length_frame_receiver
  import frx_pkg::*;
#(
  parameter int SYNC_LEN    = 3,
  parameter int HEADER_LEN  = 2,
  parameter int CHECK_LEN   = 1,
  parameter int PAYLOAD_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  data_byte,
  input  logic [6:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        frame_ready,
  output logic        frame_done,
  output logic        length_error,
  output logic        synced,
  output logic [7:0]  read_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FRAME_MAX = HEADER_LEN + PAYLOAD_MAX + CHECK_LEN;
  localparam int POS_MAX   = FRAME_MAX > SYNC_LEN ? FRAME_MAX : SYNC_LEN;
  localparam int PW        = $clog2(POS_MAX + 1);
  localparam int PW1       = PW + 1;
  localparam int RW        = (PW > 8 ? PW : 8) + 1;
  localparam int AW        = $clog2(PAYLOAD_MAX > 1 ? PAYLOAD_MAX : 2);
  localparam int HIW       = $clog2(HEADER_LEN > 1 ? HEADER_LEN : 2);
  localparam int CL        = CHECK_LEN > 0 ? CHECK_LEN : 1;
  localparam int CIW       = $clog2(CL > 1 ? CL : 2);

  // configuration
  logic [6:0] max_payload;
  logic [7:0] limit;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_MAX_PAYLOAD) begin
      max_payload <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_PAYLOAD) begin
      prdata = {25'd0, max_payload};
    end
  end

  assign limit = (8'(max_payload) > 8'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX) : 8'(max_payload);

  // frame state
  logic [PW-1:0] position, position_next;
  logic [PW-1:0] bytes_expected, bytes_expected_next;
  logic          held, held_next;
  logic [7:0]    header [HEADER_LEN];
  logic [7:0]    check  [CL];

  logic           accept;
  logic           hdr_we, chk_we, pay_we;
  logic [HIW-1:0] hdr_idx;
  logic [CIW-1:0] chk_idx;
  logic [AW-1:0]  pay_waddr, pay_raddr;
  logic           pay_re;
  logic [7:0]     pay_q;
  logic [7:0]     plen_rd;
  logic [RW-1:0]  idx;
  res_t           res;

  // output pipeline
  logic s1_valid;
  res_t s1;
  logic advance_out;

  assign advance_out = s1_valid && (!out_valid || !out_stall);
  assign in_stall    = s1_valid && out_valid && out_stall;
  assign accept      = in_valid && !in_stall;

  assign idx     = RW'(read_index);
  assign plen_rd = (header[HEADER_LEN-1] > 8'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX)
                                                            : header[HEADER_LEN-1];

  always_comb begin
    position_next       = position;
    bytes_expected_next = bytes_expected;
    held_next           = held;
    hdr_we              = 1'b0;
    hdr_idx             = position[HIW-1:0];
    chk_we              = 1'b0;
    chk_idx             = '0;
    pay_we              = 1'b0;
    pay_waddr           = '0;
    pay_re              = 1'b0;
    pay_raddr           = '0;
    res                 = '0;

    if (accept) begin
      unique case (req_t'(req_type))
        REQ_BYTE: begin
          if (!held) begin
            if (bytes_expected == '0) begin
              // hunt for the sync word
              if (position < PW'(SYNC_LEN - 1)) begin
                position_next = (data_byte == SYNC_FILL) ? position + PW'(1) : '0;
              end else if (data_byte == SYNC_LAST) begin
                position_next       = '0;
                bytes_expected_next = PW'(HEADER_LEN + CHECK_LEN);
              end else if (data_byte == SYNC_FILL) begin
                position_next = PW'(SYNC_LEN - 1);
              end else begin
                position_next = '0;
              end
            end else begin
              if (position < PW'(HEADER_LEN)) begin
                hdr_we = 1'b1;
                if (position == PW'(HEADER_LEN - 1)) begin
                  if (data_byte > limit) begin
                    res.length_error    = 1'b1;
                    position_next       = '0;
                    bytes_expected_next = '0;
                    held_next           = 1'b0;
                  end else begin
                    bytes_expected_next = bytes_expected + PW'(data_byte);
                  end
                end
              end else if (PW1'(position) + PW1'(CHECK_LEN) < PW1'(bytes_expected)) begin
                pay_we    = 1'b1;
                pay_waddr = AW'(position - PW'(HEADER_LEN));
              end else begin
                chk_we  = 1'b1;
                chk_idx = CIW'(position + PW'(CHECK_LEN) - bytes_expected);
              end
              if (!res.length_error) begin
                if (PW1'(position) + PW1'(1) == PW1'(bytes_expected_next)) begin
                  held_next      = 1'b1;
                  res.frame_done = 1'b1;
                end else begin
                  position_next = position + PW'(1);
                end
              end
            end
          end
        end
        REQ_RELEASE: begin
          position_next       = '0;
          bytes_expected_next = '0;
          held_next           = 1'b0;
        end
        REQ_READ: begin
          if (idx < RW'(HEADER_LEN)) begin
            res.read_data = header[idx[HIW-1:0]];
          end else if (idx < RW'(HEADER_LEN) + RW'(plen_rd)) begin
            pay_re      = 1'b1;
            res.use_ram = 1'b1;
            pay_raddr   = AW'(idx - RW'(HEADER_LEN));
          end else if (idx < RW'(HEADER_LEN) + RW'(plen_rd) + RW'(CHECK_LEN)) begin
            res.read_data = check[CIW'(idx - RW'(HEADER_LEN) - RW'(plen_rd))];
          end
        end
        default: begin
          // unused request code: no change
        end
      endcase
    end

    res.frame_ready = held_next;
    res.synced      = (bytes_expected_next != '0) && !held_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position       <= '0;
      bytes_expected <= '0;
      held           <= 1'b0;
    end else begin
      position       <= position_next;
      bytes_expected <= bytes_expected_next;
      held           <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      header[hdr_idx] <= data_byte;
    end
    if (chk_we) begin
      check[chk_idx] <= data_byte;
    end
  end

  frx_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_MAX)
  ) u_payload_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (data_byte),
    .re    (pay_re),
    .raddr (pay_raddr),
    .rdata (pay_q)
  );

  // RAM read stage: hold while the output register cannot take the word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance_out) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (advance_out) begin
      frame_ready  <= s1.frame_ready;
      frame_done   <= s1.frame_done;
      length_error <= s1.length_error;
      synced       <= s1.synced;
      read_data    <= s1.use_ram ? pay_q : s1.read_data;
    end
  end

endmodule

// ----- rtl/frx_checker.sv -----
// Port-level checker for the sync/length frame receiver, bound to the top level.
module frx_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        frame_ready,
  input logic        frame_done,
  input logic        length_error,
  input logic        synced,
  input logic [7:0]  read_data
);

  // a completed frame is held on the same word
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> frame_ready && !synced)
    else $error("frame_done without a held frame");

  // a dropped frame leaves the receiver hunting
  a_error_hunts: assert property (@(posedge clk) disable iff (rst)
    out_valid && length_error |-> !synced && !frame_ready && !frame_done)
    else $error("length_error while still synced or held");

  a_ready_synced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(frame_ready && synced))
    else $error("held frame reported as still collecting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(frame_ready)
      && $stable(frame_done) && $stable(length_error) && $stable(synced))
    else $error("stalled output word changed");

  // input holds off only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

endmodule

bind sync_length_frame_receiver frx_checker u_frx_checker (.*);
